FILE: rtl/core/bmre_pkg.sv
package bmre_pkg;

  localparam int IDX_W = 13;
  localparam int LEN_W = 14;
  localparam int CFG_W = 9;

  localparam int WORD_BITS_DEF = 32;
  localparam int WORDS_DEF     = 256;

  localparam logic [CFG_W-1:0] MAP_WORDS_RST = 9'd256;

  typedef enum logic [1:0] {
    CMD_FFS = 2'd0,
    CMD_FFC = 2'd1,
    CMD_SET = 2'd2,
    CMD_CLR = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t             command;
    logic [IDX_W-1:0] start_index;
    logic [LEN_W-1:0] range_length;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] bit_index;
  } out_word_t;

endpackage

FILE: rtl/core/bmre_mem.sv
module bmre_mem
  import bmre_pkg::*;
#(
  parameter int WORDS     = WORDS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int AW        = (WORDS > 1) ? $clog2(WORDS) : 1
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [WORDS];
  logic [WORD_BITS-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/bmre_split.sv
module bmre_split
  import bmre_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int PW        = $clog2(WORD_BITS),
  parameter int QW        = $clog2(((1 << IDX_W) - 1) / WORD_BITS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [IDX_W-1:0] num,
  output logic             done,
  output logic [QW-1:0]    quot,
  output logic [PW-1:0]    rem
);

  localparam int RCP = (1 << IDX_W) / WORD_BITS;
  localparam int RW  = $clog2(RCP + 1);
  localparam int PRW = IDX_W + RW;

  logic [PRW-1:0]   prod;
  logic [QW-1:0]    q0_nxt;
  logic [IDX_W-1:0] s_r;
  logic [QW-1:0]    q0_r;
  logic             v1_r;
  logic [IDX_W-1:0] qw;
  logic [IDX_W-1:0] r0;
  logic             corr;
  logic [QW-1:0]    quot_nxt;
  logic [PW-1:0]    rem_nxt;
  logic [QW-1:0]    quot_r;
  logic [PW-1:0]    rem_r;
  logic             done_r;

  assign prod   = PRW'(num) * PRW'(RCP);
  assign q0_nxt = QW'(prod >> IDX_W);

  assign qw       = IDX_W'(IDX_W'(q0_r) * IDX_W'(WORD_BITS));
  assign r0       = s_r - qw;
  assign corr     = (r0 >= IDX_W'(WORD_BITS));
  assign quot_nxt = corr ? QW'(q0_r + QW'(1)) : q0_r;
  assign rem_nxt  = corr ? PW'(r0 - IDX_W'(WORD_BITS)) : PW'(r0);

  always_ff @(posedge clk) begin
    s_r    <= num;
    q0_r   <= q0_nxt;
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (!rst_n) begin
      v1_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= go;
      done_r <= v1_r;
    end
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/core/bmre_ffs.sv
module bmre_ffs
  import bmre_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int PW        = $clog2(WORD_BITS)
) (
  input  logic [WORD_BITS-1:0] vec,
  output logic                 any,
  output logic [PW-1:0]        pos
);

  always_comb begin
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = PW'(i);
      end
    end
  end

  assign any = |vec;

endmodule

FILE: rtl/core/bitmap_search_and_range_engine_core.sv
// Allocation bitmap of WORDS words of WORD_BITS bits in one synchronous RAM. After reset the
// core clears the RAM one word per cycle, with busy high; cfg writes are taken at any time. A
// command first splits start_index into word and bit position and issues the first RAM read,
// then takes one cycle per word visited, since each word is read, scanned or updated and
// written back while the next word is read. The result strobe out_valid follows in the cycle
// after the last word is handled; a command whose search or range starts outside the map, or
// whose range is empty, visits no word. The result shows for one cycle only and cannot be
// held off; a new command may be started in that same cycle.
module bitmap_search_and_range_engine_core
  import bmre_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF,
  parameter int WORDS     = WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_word_t         in_word,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int CW  = $clog2(WORDS + 1);
  localparam int PW  = $clog2(WORD_BITS);
  localparam int QW  = $clog2(((1 << IDX_W) - 1) / WORD_BITS + 1);
  localparam int LW0 = (CW > CFG_W) ? CW : CFG_W;
  localparam int LW  = (LW0 > QW) ? LW0 : QW;
  localparam int BW0 = $clog2(WORDS * WORD_BITS);
  localparam int BW  = (BW0 > 0) ? BW0 : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPLIT,
    ST_RUN
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_r, clr_nxt;
  logic [CFG_W-1:0] map_words_r;
  cmd_t             cmd_r, cmd_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [IDX_W-1:0] start_r, start_nxt;
  logic [LW-1:0]    w_r, w_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [BW-1:0]    base_r, base_nxt;
  logic             out_valid_r;
  out_word_t        out_r, out_nxt;

  logic                 emit;
  logic                 res_found;
  logic [IDX_W-1:0]     res_idx;
  logic                 go;
  logic                 split_done;
  logic [QW-1:0]        split_quot;
  logic [PW-1:0]        split_rem;
  logic [LW-1:0]        qx;
  logic [LW-1:0]        map_ext;
  logic [LW-1:0]        lim;
  logic [LW-1:0]        w_inc;
  logic                 is_srch;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [WORD_BITS-1:0] rd_data;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] ones;
  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_keep;
  logic [WORD_BITS-1:0] fmask;
  logic [WORD_BITS-1:0] rng_data;
  logic [WORD_BITS-1:0] srch_data;
  logic [WORD_BITS-1:0] hit;
  logic                 hit_any;
  logic [PW-1:0]        hit_pos;
  logic [PW:0]          span;
  logic [PW:0]          sh_end;
  logic                 last_rng;

  bmre_split #(
    .WORD_BITS (WORD_BITS),
    .PW        (PW),
    .QW        (QW)
  ) u_split (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .num   (in_word.start_index),
    .done  (split_done),
    .quot  (split_quot),
    .rem   (split_rem)
  );

  bmre_mem #(
    .WORDS     (WORDS),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  bmre_ffs #(
    .WORD_BITS (WORD_BITS),
    .PW        (PW)
  ) u_ffs (
    .vec (hit),
    .any (hit_any),
    .pos (hit_pos)
  );

  assign map_ext = LW'(map_words_r);
  assign lim     = (map_ext > LW'(WORDS)) ? LW'(WORDS) : map_ext;
  assign qx      = LW'(split_quot);
  assign w_inc   = w_r + LW'(1);
  assign is_srch = (cmd_r == CMD_FFS) || (cmd_r == CMD_FFC);

  assign ones      = '1;
  assign lo_mask   = ones << pos_r;
  assign srch_data = (cmd_r == CMD_FFS) ? rd_data : ~rd_data;
  assign hit       = srch_data & lo_mask;

  assign span     = (PW + 1)'(WORD_BITS) - (PW + 1)'(pos_r);
  assign last_rng = (rem_r <= LEN_W'(span));
  assign sh_end   = (PW + 1)'(pos_r) + rem_r[PW:0];
  assign hi_keep  = (rem_r >= LEN_W'(span)) ? ones : ~(ones << sh_end);
  assign fmask    = lo_mask & hi_keep;
  assign rng_data = (cmd_r == CMD_SET) ? (rd_data | fmask) : (rd_data & ~fmask);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    rem_nxt   = rem_r;
    start_nxt = start_r;
    w_nxt     = w_r;
    pos_nxt   = pos_r;
    base_nxt  = base_r;
    emit      = 1'b0;
    res_found = 1'b0;
    res_idx   = '0;
    go        = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = w_inc[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = w_r[AW-1:0];
    wr_data   = rng_data;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
        if (clr_r == AW'(WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + AW'(1);
        end
      end
      ST_IDLE: begin
        if (start) begin
          go        = 1'b1;
          cmd_nxt   = in_word.command;
          rem_nxt   = in_word.range_length;
          start_nxt = in_word.start_index;
          state_nxt = ST_SPLIT;
        end
      end
      ST_SPLIT: begin
        if (split_done) begin
          w_nxt    = qx;
          pos_nxt  = split_rem;
          base_nxt = BW'(start_r - IDX_W'(split_rem));
          if (is_srch ? (qx >= lim) : ((qx >= LW'(WORDS)) || (rem_r == '0))) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = qx[AW-1:0];
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (is_srch) begin
          if (hit_any) begin
            emit      = 1'b1;
            res_found = 1'b1;
            res_idx   = IDX_W'(base_r + BW'(hit_pos));
            state_nxt = ST_IDLE;
          end else if (w_inc >= lim) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            rd_en    = 1'b1;
            w_nxt    = w_inc;
            pos_nxt  = '0;
            base_nxt = base_r + BW'(WORD_BITS);
          end
        end else begin
          wr_en = 1'b1;
          if (last_rng || (w_inc >= LW'(WORDS))) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            w_nxt   = w_inc;
            pos_nxt = '0;
            rem_nxt = rem_r - LEN_W'(span);
          end
        end
      end
    endcase
    out_nxt = out_r;
    if (emit) begin
      out_nxt.found     = res_found;
      out_nxt.bit_index = res_idx;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    rem_r   <= rem_nxt;
    start_r <= start_nxt;
    w_r     <= w_nxt;
    pos_r   <= pos_nxt;
    base_r  <= base_nxt;
    out_r   <= out_nxt;
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      map_words_r <= MAP_WORDS_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= emit;
      if (cfg_we) begin
        map_words_r <= cfg_wdata;
      end
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

FILE: rtl/core/bmre_chk.sv
module bmre_chk
  import bmre_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command was taken");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a command in progress");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result word in the cycle after a command was taken");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.found) |-> (out_word.bit_index == '0))
    else $error("nonzero bit index without a hit");

endmodule

bind bitmap_search_and_range_engine_core bmre_chk u_bmre_chk (.*);
